// ===== rtl/core/ipv4rhc_pkg.sv =====
package ipv4rhc_pkg;

    // apb register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef logic [2:0] t_reg_index;

    localparam t_reg_index REG_LOCAL_ADDRESS     = 3'd0;
    localparam t_reg_index REG_SUBNET_BROADCAST  = 3'd1;
    localparam t_reg_index REG_PROTO_SLOT_ZERO   = 3'd2;
    localparam t_reg_index REG_PROTO_SLOT_ONE    = 3'd3;
    localparam t_reg_index REG_PROTO_SLOT_TWO    = 3'd4;
    localparam t_reg_index REG_PROTO_SLOT_THREE  = 3'd5;
    localparam t_reg_index REG_PROTO_SLOT_ENABLE = 3'd6;
    localparam t_reg_index REG_ICMP_REPLY_ENABLE = 3'd7;

    // protocol slots that have a register behind them
    localparam int SLOT_REGS = 4;

    // header layout
    localparam int ADDRESS_BYTES = 4;
    localparam int SRC_OFFSET    = 12;
    localparam int DST_OFFSET    = SRC_OFFSET + ADDRESS_BYTES;
    localparam int TTL_OFFSET    = 8;
    localparam int PROTO_OFFSET  = 9;
    localparam int TLEN_HI_OFS   = 2;
    localparam int TLEN_LO_OFS   = 3;
    localparam int MIN_HDR_WORDS = 5;

    typedef logic [2:0] t_verdict;

    localparam t_verdict VERDICT_DELIVER      = 3'd0;
    localparam t_verdict VERDICT_ICMP_UNREACH = 3'd1;
    localparam t_verdict VERDICT_DROP         = 3'd2;
    localparam t_verdict VERDICT_BAD_CHECKSUM = 3'd3;
    localparam t_verdict VERDICT_ZERO_TTL     = 3'd4;
    localparam t_verdict VERDICT_BAD_LENGTH   = 3'd5;
    localparam t_verdict VERDICT_NOT_OURS     = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_rx_beat;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  protocol;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
        logic [31:0] source_address;
        logic [6:0]  icmp_reply_bytes;
    } t_verdict_item;

endpackage

// ===== rtl/core/ipv4_receive_header_check.sv =====
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-----------------------------
// packet in | in        | i_in_valid / o_in_stall | i_in_data  (t_rx_beat)
// verdict   | out       | o_out_valid / i_out_stall | o_out_data (t_verdict_item)
// config    | in        | apb psel/penable/pwrite | paddr, pwdata -> prdata
//
// one packet byte is taken every cycle while the input is not stalled; a byte is held in the
// input register and then folded into the header state
// a packet's verdict is loaded into the result register as its last byte leaves the input register
// reset (synchronous, active low) clears the packet state and restores the
// register defaults; no clearing pass is needed
// the input stalls only while a last byte waits for a result register that
// holds an earlier verdict the sink has not taken
module ipv4_receive_header_check #(
    parameter int PROTOCOL_SLOTS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ipv4rhc_pkg::t_rx_beat             i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ipv4rhc_pkg::t_verdict_item        o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipv4rhc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ipv4rhc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ipv4rhc_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);
    import ipv4rhc_pkg::*;

    // slots that are both configured and looked at
    localparam int CHECK_SLOTS = (PROTOCOL_SLOTS < SLOT_REGS) ? PROTOCOL_SLOTS : SLOT_REGS;

    // configuration registers
    logic [31:0] r_local_address;
    logic [31:0] r_subnet_broadcast;
    logic [7:0]  r_proto_slot [SLOT_REGS];
    logic [3:0]  r_proto_slot_enable;
    logic        r_icmp_reply_enable;

    // input register
    logic        r_in_valid;
    t_rx_beat    r_in_data;

    // per-packet header state
    logic [16:0] r_byte_count,       n_byte_count;
    logic [15:0] r_sum_accumulator,  n_sum_accumulator;
    logic [7:0]  r_high_byte_hold,   n_high_byte_hold;
    logic [3:0]  r_header_words,     n_header_words;
    logic [15:0] r_total_length,     n_total_length;
    logic [7:0]  r_ttl_value,        n_ttl_value;
    logic [7:0]  r_protocol_field,   n_protocol_field;
    logic [31:0] r_source_field,     n_source_field;
    logic [31:0] r_target_field,     n_target_field;

    // result register
    logic          r_out_valid;
    t_verdict_item r_out_data, n_out_data;

    logic        in_accept;
    logic        out_free;
    logic        proc_go;
    logic        cfg_write;
    t_reg_index  cfg_index;

    logic [7:0]  beat_byte;
    logic [5:0]  hdr_bytes;
    logic [16:0] hdr_bytes_ext;
    logic        in_header;
    logic [16:0] sum_wide;
    logic        bad_length;
    logic        addr_ok;
    logic        proto_known;
    logic [16:0] payload_diff;

    // ---------------- handshakes ----------------
    // result register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // a held byte moves on unless it closes a packet and the verdict has nowhere to go
    assign proc_go    = r_in_valid && (!r_in_data.last_byte || out_free);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // ---------------- header state update ----------------
    always_comb begin
        n_byte_count      = r_byte_count;
        n_sum_accumulator = r_sum_accumulator;
        n_high_byte_hold  = r_high_byte_hold;
        n_header_words    = r_header_words;
        n_total_length    = r_total_length;
        n_ttl_value       = r_ttl_value;
        n_protocol_field  = r_protocol_field;
        n_source_field    = r_source_field;
        n_target_field    = r_target_field;

        beat_byte = r_in_data.data_byte;

        // first byte carries version and ihl; ihl is live for this same byte
        if (r_byte_count == 17'd0) begin
            n_header_words = beat_byte[3:0];
        end
        hdr_bytes     = {n_header_words, 2'b00};
        hdr_bytes_ext = {11'd0, hdr_bytes};
        in_header     = r_byte_count < hdr_bytes_ext;

        // one's-complement sum of header words, end-around carry folded in
        sum_wide = {1'b0, r_sum_accumulator} + {1'b0, r_high_byte_hold, beat_byte};
        if (in_header) begin
            if (!r_byte_count[0]) begin
                n_high_byte_hold = beat_byte;
            end else begin
                n_sum_accumulator = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        if (r_byte_count == 17'(TLEN_HI_OFS)) begin
            n_total_length[15:8] = beat_byte;
        end
        if (r_byte_count == 17'(TLEN_LO_OFS)) begin
            n_total_length[7:0] = beat_byte;
        end
        if (r_byte_count == 17'(TTL_OFFSET)) begin
            n_ttl_value = beat_byte;
        end
        if (r_byte_count == 17'(PROTO_OFFSET)) begin
            n_protocol_field = beat_byte;
        end
        if (r_byte_count >= 17'(SRC_OFFSET) &&
            r_byte_count < 17'(SRC_OFFSET + ADDRESS_BYTES)) begin
            n_source_field = {r_source_field[23:0], beat_byte};
        end
        if (r_byte_count >= 17'(DST_OFFSET) &&
            r_byte_count < 17'(DST_OFFSET + ADDRESS_BYTES)) begin
            n_target_field = {r_target_field[23:0], beat_byte};
        end

        // saturates at 65536, meaning an oversize packet
        if (!r_byte_count[16]) begin
            n_byte_count = r_byte_count + 17'd1;
        end
    end

    // ---------------- verdict ----------------
    always_comb begin
        bad_length = (n_header_words < 4'(MIN_HDR_WORDS)) ||
                     (n_byte_count < hdr_bytes_ext) || n_byte_count[16];

        addr_ok = (n_target_field == 32'hFFFF_FFFF) ||
                  (n_target_field == r_subnet_broadcast) ||
                  (n_target_field == r_local_address);

        proto_known = 1'b0;
        for (int i = 0; i < CHECK_SLOTS; i++) begin
            if (r_proto_slot_enable[i] && (r_proto_slot[i] == n_protocol_field)) begin
                proto_known = 1'b1;
            end
        end

        n_out_data = '0;
        if (bad_length) begin
            n_out_data.verdict = VERDICT_BAD_LENGTH;
        end else if (n_sum_accumulator != 16'hFFFF) begin
            n_out_data.verdict = VERDICT_BAD_CHECKSUM;
        end else if (n_ttl_value == 8'd0) begin
            n_out_data.verdict = VERDICT_ZERO_TTL;
        end else if ({1'b0, n_total_length} != n_byte_count) begin
            n_out_data.verdict = VERDICT_BAD_LENGTH;
        end else if (!addr_ok) begin
            n_out_data.verdict = VERDICT_NOT_OURS;
        end else if (proto_known) begin
            n_out_data.verdict = VERDICT_DELIVER;
        end else if (r_icmp_reply_enable) begin
            n_out_data.verdict = VERDICT_ICMP_UNREACH;
        end else begin
            n_out_data.verdict = VERDICT_DROP;
        end

        // payload clamps at 65535 when the count saturated with no header
        payload_diff = n_byte_count - hdr_bytes_ext;
        if (n_byte_count > hdr_bytes_ext) begin
            n_out_data.payload_bytes = payload_diff[16] ? 16'hFFFF : payload_diff[15:0];
        end else begin
            n_out_data.payload_bytes = 16'd0;
        end

        n_out_data.protocol         = n_protocol_field;
        n_out_data.header_bytes     = hdr_bytes;
        n_out_data.source_address   = n_source_field;
        n_out_data.icmp_reply_bytes = {({1'b0, n_header_words} + 5'd3), 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count      <= '0;
            r_sum_accumulator <= '0;
            r_high_byte_hold  <= '0;
            r_header_words    <= '0;
            r_total_length    <= '0;
            r_ttl_value       <= '0;
            r_protocol_field  <= '0;
            r_source_field    <= '0;
            r_target_field    <= '0;
        end else if (proc_go) begin
            if (r_in_data.last_byte) begin
                // packet closed, start clean for the next one
                r_byte_count      <= '0;
                r_sum_accumulator <= '0;
                r_high_byte_hold  <= '0;
                r_header_words    <= '0;
                r_total_length    <= '0;
                r_ttl_value       <= '0;
                r_protocol_field  <= '0;
                r_source_field    <= '0;
                r_target_field    <= '0;
            end else begin
                r_byte_count      <= n_byte_count;
                r_sum_accumulator <= n_sum_accumulator;
                r_high_byte_hold  <= n_high_byte_hold;
                r_header_words    <= n_header_words;
                r_total_length    <= n_total_length;
                r_ttl_value       <= n_ttl_value;
                r_protocol_field  <= n_protocol_field;
                r_source_field    <= n_source_field;
                r_target_field    <= n_target_field;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_in_data.last_byte) begin
            r_out_data <= n_out_data;
        end
    end

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address     <= 32'h0000_0000;
            r_subnet_broadcast  <= 32'hFFFF_FFFF;
            r_proto_slot[0]     <= 8'd1;
            r_proto_slot[1]     <= 8'd6;
            r_proto_slot[2]     <= 8'd17;
            r_proto_slot[3]     <= 8'd0;
            r_proto_slot_enable <= 4'd7;
            r_icmp_reply_enable <= 1'b1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_LOCAL_ADDRESS:     r_local_address     <= pwdata;
                REG_SUBNET_BROADCAST:  r_subnet_broadcast  <= pwdata;
                REG_PROTO_SLOT_ZERO:   r_proto_slot[0]     <= pwdata[7:0];
                REG_PROTO_SLOT_ONE:    r_proto_slot[1]     <= pwdata[7:0];
                REG_PROTO_SLOT_TWO:    r_proto_slot[2]     <= pwdata[7:0];
                REG_PROTO_SLOT_THREE:  r_proto_slot[3]     <= pwdata[7:0];
                REG_PROTO_SLOT_ENABLE: r_proto_slot_enable <= pwdata[3:0];
                REG_ICMP_REPLY_ENABLE: r_icmp_reply_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_LOCAL_ADDRESS:     prdata = r_local_address;
            REG_SUBNET_BROADCAST:  prdata = r_subnet_broadcast;
            REG_PROTO_SLOT_ZERO:   prdata = {24'd0, r_proto_slot[0]};
            REG_PROTO_SLOT_ONE:    prdata = {24'd0, r_proto_slot[1]};
            REG_PROTO_SLOT_TWO:    prdata = {24'd0, r_proto_slot[2]};
            REG_PROTO_SLOT_THREE:  prdata = {24'd0, r_proto_slot[3]};
            REG_PROTO_SLOT_ENABLE: prdata = {28'd0, r_proto_slot_enable};
            REG_ICMP_REPLY_ENABLE: prdata = {31'd0, r_icmp_reply_enable};
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/ipv4rhc_checker.sv =====
module ipv4rhc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input ipv4rhc_pkg::t_verdict_item        o_out_data
);
    import ipv4rhc_pkg::*;

    logic passed;
    assign passed = (o_out_data.verdict == VERDICT_DELIVER) ||
                    (o_out_data.verdict == VERDICT_ICMP_UNREACH) ||
                    (o_out_data.verdict == VERDICT_DROP);

    // reset empties both registers
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall still set after reset");

    // a stalled verdict beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict beat dropped while stalled");

    // a stalled verdict beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("verdict payload changed while stalled");

    // a packet that passed the checks had a full header and a matching reply size
    a_pass_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && passed |->
            (o_out_data.header_bytes >= 6'd20) &&
            (o_out_data.icmp_reply_bytes == ({1'b0, o_out_data.header_bytes} + 7'd12)))
        else $error("passing verdict with inconsistent header length");

endmodule

bind ipv4_receive_header_check ipv4rhc_checker u_ipv4rhc_checker (.*);
